### design/assert_macros.svh
// Assertion macros for the checker file, rtis_checker.sv.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`define CHK_IMPL(lbl, clk, rst, a, b) \
  lbl: assert property (@(posedge clk) disable iff (!rst) (a) |-> (b)) \
    else $error("check failed");
`define CHK_NEXT(lbl, clk, rst, a, b) \
  lbl: assert property (@(posedge clk) disable iff (!rst) (a) |=> (b)) \
    else $error("check failed");
`endif

### design/rtis_pkg.sv
// Package for the rigid transform inlier scorer: constants, types, helpers.
// No dependencies.
package rtis_pkg;
  localparam int DefMaxPairs = 4096;
  localparam int QW = 4;
  localparam logic [1:0] CFG_ROW_X = 2'd0;
  localparam logic [1:0] CFG_ROW_Y = 2'd1;
  localparam logic [1:0] CFG_ROW_Z = 2'd2;
  localparam logic [1:0] CFG_THR = 2'd3;

  typedef struct packed {
    logic        inlier;
    logic        last;
    logic [31:0] sq;
  } rtis_item_t;

  function automatic logic signed [18:0] rtis_row(
    input logic [63:0] row, input logic signed [15:0] x,
    input logic signed [15:0] y, input logic signed [15:0] z);
    logic signed [33:0] acc;
    begin
      acc = 34'(signed'(row[63:48]) * x) + 34'(signed'(row[47:32]) * y)
          + 34'(signed'(row[31:16]) * z) + 34'sd8192;
      rtis_row = 19'(acc >>> 14) + 19'(signed'(row[15:0]));
    end
  endfunction
endpackage

### design/rtis_front.sv
// Front: registered transform and squared-error stages, inlier decision.
// Depends on rtis_pkg.
module rtis_front import rtis_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [95:0] in_tdata,
  input  logic        in_tlast,
  input  logic [63:0] row_x,
  input  logic [63:0] row_y,
  input  logic [63:0] row_z,
  input  logic [31:0] thr,
  input  logic        q_full,
  output logic        q_push,
  output rtis_item_t  q_item
);
  logic               v1_r, v2_r, l1_r;
  logic signed [18:0] dx_r, dy_r, dz_r;
  logic [38:0]        sq_r;
  logic               l2_r;
  logic               go;
  logic [38:0]        sq_nxt;
  assign go = !(v2_r && q_full);
  assign in_tready = go;
  assign sq_nxt = 39'(dx_r * dx_r) + 39'(dy_r * dy_r) + 39'(dz_r * dz_r);
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else if (go) begin
      v1_r <= in_tvalid;
      v2_r <= v1_r;
    end
    if (go) begin
      l1_r <= in_tlast;
      dx_r <= 19'(rtis_row(row_x, in_tdata[15:0], in_tdata[31:16], in_tdata[47:32]))
            - 19'(signed'(in_tdata[63:48]));
      dy_r <= 19'(rtis_row(row_y, in_tdata[15:0], in_tdata[31:16], in_tdata[47:32]))
            - 19'(signed'(in_tdata[79:64]));
      dz_r <= 19'(rtis_row(row_z, in_tdata[15:0], in_tdata[31:16], in_tdata[47:32]))
            - 19'(signed'(in_tdata[95:80]));
      sq_r <= sq_nxt;
      l2_r <= l1_r;
    end
  end
  assign q_push = v2_r && go;
  assign q_item.inlier = sq_r <= 39'(thr);
  assign q_item.last = l2_r;
  assign q_item.sq = sq_r[31:0];
endmodule

### design/rtis_fifo.sv
// Short queue between front and back.
// Depends on rtis_pkg.
module rtis_fifo import rtis_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       push,
  input  rtis_item_t din,
  output logic       full,
  output logic       nonempty,
  input  logic       pop,
  output rtis_item_t dout
);
  rtis_item_t         mem_r [QW];
  logic [1:0]         wp_r, rp_r;
  logic [2:0]         cnt_r;
  assign full = cnt_r == 3'(QW);
  assign nonempty = cnt_r != 3'd0;
  assign dout = mem_r[rp_r];
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= '0;
      rp_r <= '0;
      cnt_r <= '0;
    end else begin
      if (push) wp_r <= wp_r + 2'd1;
      if (pop) rp_r <= rp_r + 2'd1;
      cnt_r <= cnt_r + 3'(push) - 3'(pop);
    end
    if (push) mem_r[wp_r] <= din;
  end
endmodule

### design/rtis_back.sv
// Back: square root, accumulation and set summary with serial dividers.
// Depends on rtis_pkg.
module rtis_back import rtis_pkg::*; #(
  parameter int MAX_PAIRS = DefMaxPairs
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        q_nonempty,
  input  rtis_item_t  q_item,
  output logic        q_pop,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [63:0] out_tdata,
  output logic        out_tlast,
  output logic        out_tuser
);
  localparam int Cap = MAX_PAIRS < 4096 ? MAX_PAIRS : 4096;
  localparam logic [2:0] S_IDLE = 3'd0, S_SQRT = 3'd1, S_DIV = 3'd2, S_OUT = 3'd3;
  localparam logic [2:0] S_DIVIDE = 3'd4;
  logic [2:0]  st_r;
  logic [12:0] pc_r, ic_r, pcs_r, ics_r;
  logic [31:0] es_r, v_r, r_r, b_r;
  logic [11:0] idx_r;
  logic        inl_r, last_r;
  logic [48:0] n1_r, n2_r;
  logic [47:0] q1_r, q2_r;
  logic [5:0]  k_r;
  logic [48:0] t1, t2;
  logic        cnt_ok;
  assign cnt_ok = pc_r < 13'(Cap);
  assign q_pop = st_r == S_IDLE && q_nonempty;
  assign out_tvalid = st_r == S_OUT;
  assign t1 = {n1_r[47:0], q1_r[47]};
  assign t2 = {n2_r[47:0], q2_r[47]};
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE;
      pc_r <= '0;
      ic_r <= '0;
      es_r <= '0;
    end else begin
      unique case (st_r)
        S_IDLE: if (q_nonempty) begin
          idx_r <= pc_r > 13'd4095 ? 12'd4095 : pc_r[11:0];
          inl_r <= q_item.inlier;
          last_r <= q_item.last;
          v_r <= q_item.sq;
          r_r <= '0;
          b_r <= 32'h4000_0000;
          st_r <= (cnt_ok && q_item.inlier) ? S_SQRT : S_DIV;
          if (cnt_ok) pc_r <= pc_r + 13'd1;
        end
        S_SQRT: begin
          if (b_r == 32'd0) begin
            es_r <= es_r + r_r;
            ic_r <= ic_r + 13'd1;
            st_r <= S_DIV;
          end else if (v_r >= r_r + b_r) begin
            v_r <= v_r - (r_r + b_r);
            r_r <= (r_r >> 1) + b_r;
          end else r_r <= r_r >> 1;
          b_r <= b_r >> 2;
        end
        S_DIV: begin
          if (last_r) begin
            pcs_r <= pc_r;
            ics_r <= ic_r;
            q1_r <= {16'd0, es_r} + 48'(ic_r >> 1);
            q2_r <= {19'd0, ic_r, 16'd0} + 48'(pc_r >> 1);
            n1_r <= '0;
            n2_r <= '0;
            k_r <= 6'd48;
            st_r <= S_DIVIDE;
          end else begin
            st_r <= S_OUT;
          end
        end
        S_DIVIDE: begin
          if (k_r == 6'd0) begin
            st_r <= S_OUT;
            pc_r <= '0;
            ic_r <= '0;
            es_r <= '0;
          end else begin
            k_r <= k_r - 6'd1;
            if (t1 >= 49'(ics_r)) begin
              n1_r <= t1 - 49'(ics_r);
              q1_r <= {q1_r[46:0], 1'b1};
            end else begin
              n1_r <= t1;
              q1_r <= {q1_r[46:0], 1'b0};
            end
            if (t2 >= 49'(pcs_r)) begin
              n2_r <= t2 - 49'(pcs_r);
              q2_r <= {q2_r[46:0], 1'b1};
            end else begin
              n2_r <= t2;
              q2_r <= {q2_r[46:0], 1'b0};
            end
          end
        end
        S_OUT: if (out_tready) st_r <= S_IDLE;
        default: st_r <= S_IDLE;
      endcase
    end
  end
  always_comb begin
    out_tdata = '0;
    out_tdata[11:0] = idx_r;
    out_tdata[12] = inl_r;
    out_tlast = last_r;
    out_tuser = 1'b0;
    if (last_r) begin
      out_tdata[25:13] = ics_r;
      out_tuser = ics_r == 13'd0;
      if (ics_r != 13'd0) out_tdata[41:26] = q1_r[15:0];
      if (pcs_r != 13'd0) out_tdata[58:42] = q2_r[16:0];
    end
  end
endmodule

### design/rigid_transform_inlier_scorer_unit.sv
// Top level of the rigid transform inlier scorer.
// Depends on rtis_pkg, rtis_front, rtis_fifo, rtis_back.
// Channel  Dir  Payload
// in_      in   tdata: src_x,src_y,src_z,dst_x,dst_y,dst_z; tlast: last_pair
// out_     out  tdata: pair_index,is_inlier,inlier_count,mean_error_mm,inlier_ratio;
//               tlast: set_done; tuser: no_inliers
// cfg_     in   index (2 bits), 64-bit data
// The front takes one pair per cycle into a two-stage pipeline and a 4-deep queue.
// The back takes each pair through idle, divide-setup and output states, a counted
// inlier also through the square root loop, a last pair also through the serial
// dividers; it waits while out_tready is low. The input stalls while the queue is
// full and the second stage holds a pair. Reset is synchronous, active low.
module rigid_transform_inlier_scorer_unit import rtis_pkg::*; #(
  parameter int MAX_PAIRS = DefMaxPairs
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [95:0] in_tdata,  // src_x, src_y, src_z, dst_x, dst_y, dst_z
  input  logic        in_tlast,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [63:0] out_tdata, // pair_index, is_inlier, inlier_count, mean, ratio
  output logic        out_tlast,
  output logic        out_tuser, // no_inliers
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [63:0] cfg_data
);
  logic [63:0] rx_r, ry_r, rz_r;
  logic [31:0] thr_r;
  logic        full, ne, push, pop;
  rtis_item_t  fi, fo;
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rx_r <= 64'h4000_0000_0000_0000;
      ry_r <= 64'h0000_4000_0000_0000;
      rz_r <= 64'h0000_0000_4000_0000;
      thr_r <= 32'd10000;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_ROW_X: rx_r <= cfg_data;
        CFG_ROW_Y: ry_r <= cfg_data;
        CFG_ROW_Z: rz_r <= cfg_data;
        CFG_THR: thr_r <= cfg_data[31:0];
        default: ;
      endcase
    end
  end
  rtis_front u_front (.clk, .rst_n, .in_tvalid, .in_tready, .in_tdata, .in_tlast,
    .row_x(rx_r), .row_y(ry_r), .row_z(rz_r), .thr(thr_r), .q_full(full),
    .q_push(push), .q_item(fi));
  rtis_fifo u_fifo (.clk, .rst_n, .push, .din(fi), .full, .nonempty(ne), .pop,
    .dout(fo));
  rtis_back #(.MAX_PAIRS(MAX_PAIRS)) u_back (.clk, .rst_n, .q_nonempty(ne),
    .q_item(fo), .q_pop(pop), .out_tvalid, .out_tready, .out_tdata, .out_tlast,
    .out_tuser);
endmodule

### design/rtis_checker.sv
// Port-level checker for the inlier scorer, bound to the top level.
// Depends on assert_macros.svh.
`include "assert_macros.svh"
module rtis_checker (
  input logic clk,
  input logic rst_n,
  input logic out_tvalid,
  input logic out_tready,
  input logic out_tlast,
  input logic out_tuser,
  input logic [63:0] out_tdata
);
  `CHK_NEXT(a_hold, clk, rst_n, out_tvalid && !out_tready, out_tvalid)
  `CHK_IMPL(a_noinl, clk, rst_n, out_tvalid && out_tuser, out_tlast)
  `CHK_IMPL(a_cnt, clk, rst_n, out_tvalid && !out_tlast, out_tdata[25:13] == 13'd0)
endmodule
bind rigid_transform_inlier_scorer_unit rtis_checker u_chk (.*);

### tb/tb_rigid_transform_inlier_scorer_unit.sv
// Testbench for rigid_transform_inlier_scorer_unit: streams point pairs, predicts
// each result in-line and compares every field. Depends on rtis_pkg and the RTL.
module tb_rigid_transform_inlier_scorer_unit;
  timeunit 1ns;
  timeprecision 1ps;
  import rtis_pkg::*;

  localparam int CycleLimit = 1000000;
  localparam int PairCap = DefMaxPairs < 4096 ? DefMaxPairs : 4096;

  typedef struct packed {
    logic signed [15:0] sx, sy, sz, dx, dy, dz;
    logic               last;
  } pair_t;

  typedef struct packed {
    logic [11:0] index;
    logic        inlier;
    logic        done;
    logic [12:0] count;
    logic [15:0] mean;
    logic        empty;
    logic [16:0] ratio;
  } score_t;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [95:0] in_tdata;
  logic        in_tlast;
  logic        out_tvalid;
  logic        out_tready;
  logic [63:0] out_tdata;
  logic        out_tlast;
  logic        out_tuser;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [1:0]  cfg_index;
  logic [63:0] cfg_data;

  logic [63:0] rows [3];
  logic [31:0] thresh;
  int unsigned pairs_seen;
  int unsigned inliers_seen;
  logic [31:0] err_sum;

  score_t      score_q[$];
  int          fails;
  int          cycles;
  bit          gaps_on;
  int          hold_cycles;

  rigid_transform_inlier_scorer_unit u_top (.*);

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("tb_rigid_transform_inlier_scorer_unit: FAIL");
      $finish;
    end
  end

  always @(negedge clk) begin
    if (!rst_n) begin
      out_tready = 1'b0;
    end else if (hold_cycles > 0) begin
      out_tready = 1'b0;
      hold_cycles = hold_cycles - 1;
    end else begin
      out_tready = !(gaps_on && $urandom_range(99) < 30);
    end
  end

  function automatic longint xform(logic [63:0] row, longint x, longint y, longint z);
    longint acc;
    acc = longint'($signed(row[63:48])) * x + longint'($signed(row[47:32])) * y
        + longint'($signed(row[31:16])) * z;
    return ((acc + 8192) >>> 14) + longint'($signed(row[15:0]));
  endfunction

  function automatic logic [31:0] int_sqrt(logic [31:0] v);
    logic [31:0] r;
    logic [31:0] b;
    r = 0;
    b = 32'h4000_0000;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic score_t score_pair(pair_t p);
    score_t s;
    longint ex, ey, ez, sq;
    ex = xform(rows[0], p.sx, p.sy, p.sz) - p.dx;
    ey = xform(rows[1], p.sx, p.sy, p.sz) - p.dy;
    ez = xform(rows[2], p.sx, p.sy, p.sz) - p.dz;
    sq = ex * ex + ey * ey + ez * ez;
    s = '0;
    s.inlier = (sq <= longint'(thresh));
    s.index = (pairs_seen > 4095) ? 12'd4095 : 12'(pairs_seen);
    s.done = p.last;
    if (pairs_seen < PairCap) begin
      pairs_seen++;
      if (s.inlier) begin
        inliers_seen++;
        err_sum = err_sum + int_sqrt(32'(sq));
      end
    end
    if (p.last) begin
      s.count = 13'(inliers_seen);
      if (inliers_seen == 0) s.empty = 1'b1;
      else s.mean = 16'((longint'(err_sum) + inliers_seen / 2) / inliers_seen);
      if (pairs_seen != 0)
        s.ratio = 17'((longint'(inliers_seen) * 65536 + pairs_seen / 2) / pairs_seen);
      pairs_seen = 0;
      inliers_seen = 0;
      err_sum = 0;
    end
    return s;
  endfunction

  always @(posedge clk) begin
    score_t got, want;
    if (rst_n && out_tvalid && out_tready) begin
      got = '{index: out_tdata[11:0], inlier: out_tdata[12], done: out_tlast,
              count: out_tdata[25:13], mean: out_tdata[41:26], empty: out_tuser,
              ratio: out_tdata[58:42]};
      if (score_q.size() == 0) begin
        $display("%0t: unexpected transaction %h", $time, got);
        fails++;
      end else begin
        want = score_q.pop_front();
        if (got.index !== want.index)
          $display("%0t: pair_index exp %0d got %0d", $time, want.index, got.index);
        if (got.inlier !== want.inlier)
          $display("%0t: is_inlier exp %0d got %0d", $time, want.inlier, got.inlier);
        if (got.done !== want.done)
          $display("%0t: set_done exp %0d got %0d", $time, want.done, got.done);
        if (got.count !== want.count)
          $display("%0t: inlier_count exp %0d got %0d", $time, want.count, got.count);
        if (got.mean !== want.mean)
          $display("%0t: mean_error_mm exp %0d got %0d", $time, want.mean, got.mean);
        if (got.empty !== want.empty)
          $display("%0t: no_inliers exp %0d got %0d", $time, want.empty, got.empty);
        if (got.ratio !== want.ratio)
          $display("%0t: inlier_ratio exp %0d got %0d", $time, want.ratio, got.ratio);
        if (got !== want) fails++;
      end
    end
  end

  task automatic send_pair(pair_t p);
    while (gaps_on && $urandom_range(99) < 30) begin
      in_tvalid = 1'b0;
      @(negedge clk);
    end
    in_tvalid = 1'b1;
    in_tdata = {p.dz, p.dy, p.dx, p.sz, p.sy, p.sx};
    in_tlast = p.last;
    do @(posedge clk); while (!in_tready);
    score_q = {score_q, score_pair(p)};
    @(negedge clk);
  endtask

  task automatic drain();
    in_tvalid = 1'b0;
    while (score_q.size() != 0) @(negedge clk);
    repeat (80) @(negedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [63:0] val);
    drain();
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data = val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_ROW_X: rows[0] = val;
      CFG_ROW_Y: rows[1] = val;
      CFG_ROW_Z: rows[2] = val;
      CFG_THR:   thresh = val[31:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic set_transform(logic [63:0] rx, logic [63:0] ry, logic [63:0] rz,
                               logic [31:0] thr);
    write_reg(CFG_ROW_X, rx);
    write_reg(CFG_ROW_Y, ry);
    write_reg(CFG_ROW_Z, rz);
    write_reg(CFG_THR, {32'h0, thr});
  endtask

  function automatic logic signed [15:0] clamp16(longint v);
    if (v > 32767) return 16'sh7fff;
    if (v < -32768) return 16'sh8000;
    return 16'(v);
  endfunction

  function automatic pair_t near_pair(int spread, int noise, bit last);
    pair_t p;
    p.sx = 16'($signed($urandom_range(2 * spread)) - spread);
    p.sy = 16'($signed($urandom_range(2 * spread)) - spread);
    p.sz = 16'($signed($urandom_range(2 * spread)) - spread);
    p.dx = clamp16(xform(rows[0], p.sx, p.sy, p.sz) + $signed($urandom_range(2 * noise)) - noise);
    p.dy = clamp16(xform(rows[1], p.sx, p.sy, p.sz) + $signed($urandom_range(2 * noise)) - noise);
    p.dz = clamp16(xform(rows[2], p.sx, p.sy, p.sz) + $signed($urandom_range(2 * noise)) - noise);
    p.last = last;
    return p;
  endfunction

  function automatic pair_t wild_pair(bit last);
    pair_t p;
    p = {$urandom, $urandom, $urandom, 1'b0};
    p.last = last;
    return p;
  endfunction

  function automatic logic [63:0] rand_row();
    return {$urandom, $urandom};
  endfunction

  task automatic test_directed();
    send_pair('{0, 0, 0, 0, 0, 0, 1'b0});
    send_pair('{100, 0, 0, 200, 0, 0, 1'b0});
    send_pair('{100, 0, 0, 201, 0, 0, 1'b0});
    send_pair('{-32768, -32768, -32768, 32767, 32767, 32767, 1'b0});
    send_pair('{32767, 32767, 32767, -32768, -32768, -32768, 1'b0});
    send_pair('{5, -7, 9, 8, -3, 9, 1'b1});
    send_pair('{-32768, 32767, 0, -32768, 32767, 0, 1'b1});
    send_pair('{0, 0, 0, 32767, 0, 0, 1'b0});
    send_pair('{0, 0, 0, 0, -32768, 0, 1'b1});
    set_transform(64'h7fff_7fff_7fff_7fff, 64'h8000_8000_8000_8000,
                  64'hffff_ffff_ffff_ffff, 32'hffff_ffff);
    send_pair('{32767, 32767, 32767, 32767, -32768, 0, 1'b0});
    send_pair('{-32768, -32768, -32768, -32768, 32767, -1, 1'b0});
    send_pair('{-32768, 32767, -32768, 1, 2, 3, 1'b1});
    set_transform(64'h0, 64'h0, 64'h0, 32'h0);
    send_pair('{1234, -4321, 77, 0, 0, 0, 1'b0});
    send_pair('{1, 1, 1, 0, 0, 1, 1'b1});
    set_transform(64'h0000_4000_0000_0000, 64'hc000_0000_0000_0064,
                  64'h0000_0000_4000_ff38, 32'd10000);
    repeat (6) send_pair(near_pair(3000, 40, 1'b0));
    send_pair(near_pair(3000, 40, 1'b1));
  endtask

  task automatic test_random_sets();
    int left;
    int len;
    gaps_on = 1'b1;
    left = 300;
    while (left > 0) begin
      if ($urandom_range(3) == 0)
        set_transform($urandom_range(1) ? rand_row() : {16'h4000, 32'h0, 16'($urandom)},
                      $urandom_range(1) ? rand_row() : {16'h0, 16'h4000, 16'h0, 16'($urandom)},
                      $urandom_range(1) ? rand_row() : {32'h0, 16'h4000, 16'($urandom)},
                      $urandom_range(1) ? $urandom : $urandom_range(20000));
      len = $urandom_range(1, 24);
      for (int i = 0; i < len; i++) begin
        if ($urandom_range(99) < 80) send_pair(near_pair(30000, 60, i == len - 1));
        else send_pair(wild_pair(i == len - 1));
      end
      left -= len;
    end
  endtask

  task automatic test_backpressure();
    drain();
    gaps_on = 1'b0;
    hold_cycles = 400;
    for (int i = 0; i < 40; i++) send_pair(near_pair(500, 30, i == 39));
    gaps_on = 1'b1;
  endtask

  task automatic test_long_set();
    set_transform(64'h4000_0000_0000_0000, 64'h0000_4000_0000_0000,
                  64'h0000_0000_4000_0000, 32'd100);
    gaps_on = 1'b0;
    for (int i = 0; i < 80; i++) begin
      if (i % 20 == 0) send_pair(near_pair(1000, 4, 1'b0));
      else send_pair('{0, 0, 0, 1000, 0, 0, 1'b0});
    end
    send_pair(near_pair(1000, 4, 1'b1));
    gaps_on = 1'b1;
  endtask

  initial begin
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tlast = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = CFG_ROW_X;
    cfg_data = '0;
    out_tready = 1'b0;
    fails = 0;
    cycles = 0;
    gaps_on = 1'b0;
    hold_cycles = 0;
    rows[0] = 64'h4000_0000_0000_0000;
    rows[1] = 64'h0000_4000_0000_0000;
    rows[2] = 64'h0000_0000_4000_0000;
    thresh = 32'd10000;
    pairs_seen = 0;
    inliers_seen = 0;
    err_sum = 0;
    repeat (11) @(negedge clk);
    rst_n = 1'b1;
    test_directed();
    test_backpressure();
    test_random_sets();
    test_long_set();
    drain();
    repeat (100) @(negedge clk);
    if (fails == 0) begin
      $display("tb_rigid_transform_inlier_scorer_unit: PASS");
    end else begin
      $display("tb_rigid_transform_inlier_scorer_unit: FAIL");
    end
    $finish;
  end
endmodule
